### design/data_block_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// Data block deframer assertion macros
// Clocked assertion shorthands shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef DATA_BLOCK_DEFRAMER_TOP_MACROS_SVH
`define DATA_BLOCK_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define DBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled during reset
`define DBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

### design/dbd_pkg.sv
// ----------------------------------------------------------------------------
// Data block deframer package
// Codes, defaults and types for the data block command deframer.
// ----------------------------------------------------------------------------
package dbd_pkg;

    // Block counter width default
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Command framing
    localparam logic [7:0]  CMD_BYTE   = 8'h67;
    localparam logic [32:0] HEADER_LEN = 33'd7;

    // Register reset values
    localparam logic [31:0] STREAM_LENGTH_RESET = 32'd1;
    localparam logic [15:0] MAX_BLOCKS_RESET    = 16'd10000;

    // Configuration address map (byte address 4*index)
    localparam int         PADDR_WIDTH       = 3;
    localparam logic [0:0] REG_STREAM_LENGTH = 1'b0;
    localparam logic [0:0] REG_MAX_BLOCKS    = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_IGNORED = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_ACCEPT  = 3'd2;
    localparam logic [2:0] KIND_REJECT  = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;

    // Header byte steps after the command byte
    localparam logic [2:0] STEP_COMPAT = 3'd1;
    localparam logic [2:0] STEP_TYPE   = 3'd2;
    localparam logic [2:0] STEP_SIZE0  = 3'd3;
    localparam logic [2:0] STEP_SIZE1  = 3'd4;
    localparam logic [2:0] STEP_SIZE2  = 3'd5;
    localparam logic [2:0] STEP_SIZE3  = 3'd6;

    // Scan phase
    typedef enum logic [3:0] {
        PH_SCAN    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_IGNORE  = 4'b1000
    } phase_t;

endpackage

### design/data_block_deframer_top.sv
// ----------------------------------------------------------------------------
// Data block deframer
// Scans a command stream for data block commands and tags every byte.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while the result channel is not stalled and
// returns one tagged result per byte: ignored, header, block accepted, block
// rejected or payload, with the block type, size and index, a last-of-block
// flag and an end-of-stream flag that carries the final block count. Each
// byte passes through the input register, the single scan step and the
// result register. The user must write stream_length and max_blocks over
// the APB port only between streams; the block does not enforce it. The
// state returns to the start of a stream after the byte that ends the stream.
`include "data_block_deframer_top_macros.svh"

module data_block_deframer_top
    import dbd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Input byte channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    // Result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_kind,
    output logic [7:0]             m_out_byte,
    output logic [7:0]             m_block_type,
    output logic [31:0]            m_block_size,
    output logic [15:0]            m_block_index,
    output logic                   m_last_of_block,
    output logic                   m_stream_done,
    output logic [15:0]            m_accept_count
);

    // Configuration registers
    logic [31:0] stream_length_reg;
    logic [15:0] max_blocks_reg;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;

    // Scan state
    phase_t                 phase_reg, phase_next;
    logic [31:0]            byte_position_reg, byte_position_next;
    logic [2:0]             header_step_reg, header_step_next;
    logic [7:0]             type_hold_reg, type_hold_next;
    logic [31:0]            size_accum_reg, size_accum_next;
    logic [31:0]            payload_left_reg, payload_left_next;
    logic [COUNT_WIDTH-1:0] blocks_found_reg, blocks_found_next;

    // Result register
    logic        m_valid_reg;
    logic [2:0]  m_kind_reg, m_kind_next;
    logic [7:0]  m_out_byte_reg, m_out_byte_next;
    logic [7:0]  m_block_type_reg, m_block_type_next;
    logic [31:0] m_block_size_reg, m_block_size_next;
    logic [15:0] m_block_index_reg, m_block_index_next;
    logic        m_last_reg, m_last_next;
    logic        m_done_reg, m_done_next;
    logic [15:0] m_accept_count_reg, m_accept_count_next;

    // Scan step helpers
    logic                   cfg_write;
    logic [32:0]            pos_plus1;
    logic                   stream_end;
    logic [31:0]            size_new;
    logic [31:0]            left_dec;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [COUNT_WIDTH-1:0] count_dec;
    logic                   limit_inc;
    logic                   limit_cur;

    // APB write and read
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_STREAM_LENGTH: prdata = stream_length_reg;
            REG_MAX_BLOCKS:    prdata = {16'd0, max_blocks_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_length_reg <= STREAM_LENGTH_RESET;
            max_blocks_reg    <= MAX_BLOCKS_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_STREAM_LENGTH: stream_length_reg <= pwdata;
                REG_MAX_BLOCKS:    max_blocks_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Handshake: the step runs when a byte is held and the result slot frees up
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Counter arithmetic and stop conditions
    assign pos_plus1 = {1'b0, byte_position_reg} + 33'd1;
    assign stream_end = pos_plus1 >= {1'b0, stream_length_reg};
    assign left_dec  = payload_left_reg - 32'd1;
    assign count_inc = blocks_found_reg + COUNT_WIDTH'(1);
    assign count_dec = blocks_found_reg - COUNT_WIDTH'(1);
    assign limit_inc = (32'(count_inc) >= 32'(max_blocks_reg)) || (&count_inc);
    assign limit_cur = (32'(blocks_found_reg) >= 32'(max_blocks_reg)) || (&blocks_found_reg);

    // Merge the size byte of this header step
    always_comb begin
        size_new = size_accum_reg;
        case (header_step_reg)
            STEP_SIZE0: size_new[7:0]   = size_accum_reg[7:0]   | in_byte_reg;
            STEP_SIZE1: size_new[15:8]  = size_accum_reg[15:8]  | in_byte_reg;
            STEP_SIZE2: size_new[23:16] = size_accum_reg[23:16] | in_byte_reg;
            STEP_SIZE3: size_new[31:24] = size_accum_reg[31:24] | in_byte_reg;
            default: ;
        endcase
    end

    // Scan step for one byte
    always_comb begin
        phase_next         = phase_reg;
        byte_position_next = byte_position_reg;
        header_step_next   = header_step_reg;
        type_hold_next     = type_hold_reg;
        size_accum_next    = size_accum_reg;
        payload_left_next  = payload_left_reg;
        blocks_found_next  = blocks_found_reg;

        m_kind_next        = KIND_IGNORED;
        m_out_byte_next    = 8'd0;
        m_block_type_next  = 8'd0;
        m_block_size_next  = 32'd0;
        m_block_index_next = 16'd0;
        m_last_next        = 1'b0;

        case (phase_reg)
            PH_SCAN: begin
                if (in_byte_reg == CMD_BYTE &&
                    ({1'b0, byte_position_reg} + HEADER_LEN) < {1'b0, stream_length_reg}) begin
                    m_kind_next      = KIND_HEADER;
                    phase_next       = PH_HEADER;
                    header_step_next = STEP_COMPAT;
                    type_hold_next   = 8'd0;
                    size_accum_next  = 32'd0;
                end
            end
            PH_HEADER: begin
                if (header_step_reg == STEP_TYPE) begin
                    type_hold_next = in_byte_reg;
                end
                size_accum_next = size_new;
                if (header_step_reg >= STEP_SIZE3) begin
                    m_block_type_next = type_hold_reg;
                    m_block_size_next = size_new;
                    header_step_next  = 3'd0;
                    if ((pos_plus1 + {1'b0, size_new}) <= {1'b0, stream_length_reg}) begin
                        // Block fits in the rest of the stream
                        m_kind_next        = KIND_ACCEPT;
                        m_block_index_next = 16'(blocks_found_reg);
                        blocks_found_next  = count_inc;
                        if (size_new == 32'd0) begin
                            m_last_next = 1'b1;
                            phase_next  = limit_inc ? PH_IGNORE : PH_SCAN;
                        end else begin
                            payload_left_next = size_new;
                            phase_next        = PH_PAYLOAD;
                        end
                    end else begin
                        // Oversized block: drop the rest of the stream
                        m_kind_next = KIND_REJECT;
                        phase_next  = PH_IGNORE;
                    end
                end else begin
                    m_kind_next      = KIND_HEADER;
                    header_step_next = header_step_reg + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                m_kind_next        = KIND_PAYLOAD;
                m_out_byte_next    = in_byte_reg;
                m_block_type_next  = type_hold_reg;
                m_block_size_next  = size_accum_reg;
                m_block_index_next = 16'(count_dec);
                payload_left_next  = left_dec;
                if (left_dec == 32'd0) begin
                    m_last_next = 1'b1;
                    phase_next  = limit_cur ? PH_IGNORE : PH_SCAN;
                end
            end
            PH_IGNORE: ;
            default: phase_next = PH_SCAN;
        endcase

        m_done_next         = stream_end;
        m_accept_count_next = 16'(blocks_found_next);

        // Restart the scan after the last byte of the stream
        if (stream_end) begin
            phase_next         = PH_SCAN;
            byte_position_next = 32'd0;
            header_step_next   = 3'd0;
            type_hold_next     = 8'd0;
            size_accum_next    = 32'd0;
            payload_left_next  = 32'd0;
            blocks_found_next  = '0;
        end else begin
            byte_position_next = byte_position_reg + 32'd1;
        end
    end

    // Advance the scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_SCAN;
            byte_position_reg <= 32'd0;
            header_step_reg   <= 3'd0;
            type_hold_reg     <= 8'd0;
            size_accum_reg    <= 32'd0;
            payload_left_reg  <= 32'd0;
            blocks_found_reg  <= '0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            byte_position_reg <= byte_position_next;
            header_step_reg   <= header_step_next;
            type_hold_reg     <= type_hold_next;
            size_accum_reg    <= size_accum_next;
            payload_left_reg  <= payload_left_next;
            blocks_found_reg  <= blocks_found_next;
        end
    end

    // Result register: load on a step, drop after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_kind_reg         <= m_kind_next;
            m_out_byte_reg     <= m_out_byte_next;
            m_block_type_reg   <= m_block_type_next;
            m_block_size_reg   <= m_block_size_next;
            m_block_index_reg  <= m_block_index_next;
            m_last_reg         <= m_last_next;
            m_done_reg         <= m_done_next;
            m_accept_count_reg <= m_accept_count_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_out_byte      = m_out_byte_reg;
    assign m_block_type    = m_block_type_reg;
    assign m_block_size    = m_block_size_reg;
    assign m_block_index   = m_block_index_reg;
    assign m_last_of_block = m_last_reg;
    assign m_stream_done   = m_done_reg;
    assign m_accept_count  = m_accept_count_reg;

    // Checks
    `DBD_ASSERT_IMPL(a_payload_left_nonzero, aclk, aresetn,
        phase_reg == PH_PAYLOAD, payload_left_reg != 32'd0)
    `DBD_ASSERT_IMPL(a_header_step_range, aclk, aresetn,
        phase_reg == PH_HEADER,
        header_step_reg >= STEP_COMPAT && header_step_reg <= STEP_SIZE3)
    `DBD_ASSERT_IMPL(a_empty_block_last, aclk, aresetn,
        m_valid_reg && m_kind_reg == KIND_ACCEPT && m_block_size_reg == 32'd0,
        m_last_reg)
    `DBD_ASSERT_NEXT(a_restart_on_end, aclk, aresetn,
        advance && stream_end, byte_position_reg == 32'd0 && phase_reg == PH_SCAN)

endmodule
